// File: src/mae_pkg.sv
// Shared types and constants for the matrix arithmetic engine.
`timescale 1ns / 1ps
`default_nettype none
package mae_pkg;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int CNT_W       = 7;
    localparam int IDX_OUT_W   = 3;
    localparam int MAX_DIM_DEF = 8;
    localparam int FRAC_DEF    = 16;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_A_ROWS = 2'd1;
    localparam logic [1:0] CFG_A_COLS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    typedef enum logic [1:0] {
        MODE_MUL = 2'd0,
        MODE_ADD = 2'd1,
        MODE_SUB = 2'd2,
        MODE_TRN = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_OUT,
        S_DONE
    } t_state;

    // store write from the loader
    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [CNT_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_wr;

    // one queued operation with its clamped sizes
    typedef struct packed {
        t_mode            mode;
        logic [DIM_W-1:0] ar;
        logic [DIM_W-1:0] ac;
        logic [DIM_W-1:0] bc;
    } t_job;

    typedef struct packed {
        logic [DATA_W-1:0]    value;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 sat;
        logic                 last;
    } t_res;
endpackage
`default_nettype wire

// File: src/matrix_arith_engine.sv
// Top level of the streaming fixed-point matrix arithmetic engine.
// Usage:
//  - Config: i_cfg_we / i_cfg_idx / i_cfg_data write mode, a_rows, a_cols,
//    b_cols; write only while the engine is idle. Sizes of 0 act as 1,
//    sizes above MAX_DIM act as MAX_DIM.
//  - Input queue side: an element transfers when push is high and full
//    is low. Elements are A then B (B skipped in transpose), row-major.
//  - Output queue side: the oldest result sits on the o_ ports while
//    empty is low and transfers when pop is high.
//  - Loading stores each transferred element in turn. The element
//    completing the load raises full until the whole result has been
//    computed and queued. In multiply mode the sequencer steps through
//    read, multiply and accumulate for each term of a result element, then
//    output; otherwise through read, multiply state and output. The single
//    shared multiply-accumulate path with registered store reads sets the pace.
//  - A stalled receiver fills a 4-entry result FIFO, after which the
//    compute sequencer holds; nothing is dropped.
//  - Synchronous reset restores config defaults (multiply, 4x4x4) and
//    starts loading a fresh A; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module matrix_arith_engine #(
    parameter int MAX_DIM   = mae_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mae_pkg::FRAC_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [mae_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [mae_pkg::DATA_W-1:0]    i_elem_value,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [mae_pkg::DATA_W-1:0]         o_result_value,
    output logic [mae_pkg::IDX_OUT_W-1:0]      o_result_row,
    output logic [mae_pkg::IDX_OUT_W-1:0]      o_result_col,
    output logic                               o_saturated,
    output logic                               o_last
);
    import mae_pkg::*;

    t_wr  wr;
    t_job job_in, job_out;
    t_res res;
    logic job_push, job_valid, job_pop, job_done;

    mae_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_elem_value (i_elem_value),
        .i_job_done   (job_done),
        .o_wr         (wr),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    mae_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    mae_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_job_done  (job_done),
        .pop         (pop),
        .empty       (empty),
        .o_res       (res)
    );

    assign o_result_value = res.value;
    assign o_result_row   = res.row;
    assign o_result_col   = res.col;
    assign o_saturated    = res.sat;
    assign o_last         = res.last;
endmodule
`default_nettype wire

// File: src/mae_front.sv
// Loader: config registers, element counting, store writes, job issue.
`timescale 1ns / 1ps
`default_nettype none
module mae_front #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [mae_pkg::DIM_W-1:0] i_cfg_data,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [mae_pkg::DATA_W-1:0] i_elem_value,
    input  wire logic                      i_job_done,
    output mae_pkg::t_wr                   o_wr,
    output logic                           o_job_push,
    output mae_pkg::t_job                  o_job
);
    import mae_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    t_mode            r_mode;
    logic [DIM_W-1:0] r_ar, r_ac, r_bc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_lb, n_lb;
    logic             r_open;

    logic [DIM_W-1:0]   ar, ac, bc;
    logic               lb_eff, accept, issue;
    logic [CNT_W-1:0]   cnt, cnt1;
    logic [2*DIM_W-1:0] need;

    function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] d);
        if (d == '0) return DIM_W'(1);
        if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return d;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MUL;
            r_ar   <= DIM_W'(4);
            r_ac   <= DIM_W'(4);
            r_bc   <= DIM_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_A_ROWS: r_ar   <= i_cfg_data;
                CFG_A_COLS: r_ac   <= i_cfg_data;
                CFG_B_COLS: r_bc   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ar     = clamp(r_ar);
    assign ac     = clamp(r_ac);
    assign bc     = clamp(r_bc);
    assign full   = r_open;
    assign accept = push && !r_open;
    // transpose picked while waiting for B drops A and restarts
    assign lb_eff = r_lb && (r_mode != MODE_TRN);
    assign cnt    = (r_lb && r_mode == MODE_TRN) ? '0 : r_cnt;
    assign cnt1   = cnt + CNT_W'(1);

    always_comb begin
        need  = (lb_eff && r_mode == MODE_MUL) ? ac * bc : ar * ac;
        n_cnt = r_cnt;
        n_lb  = r_lb;
        issue = 1'b0;
        if (accept) begin
            if ({1'b0, cnt1} < need) begin
                n_cnt = cnt1;
                n_lb  = lb_eff;
            end else begin
                n_cnt = '0;
                if (!lb_eff && r_mode != MODE_TRN) begin
                    n_lb = 1'b1;
                end else begin
                    n_lb  = 1'b0;
                    issue = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_lb   <= 1'b0;
            r_open <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_lb  <= n_lb;
            if (issue) begin
                r_open <= 1'b1;
            end else if (i_job_done) begin
                r_open <= 1'b0;
            end
        end
    end

    always_comb begin
        o_wr.we_a = accept && !lb_eff && (cnt < CNT_W'(DEPTH));
        o_wr.we_b = accept && lb_eff && (cnt < CNT_W'(DEPTH));
        o_wr.addr = cnt;
        o_wr.data = i_elem_value;
    end

    assign o_job_push = issue;
    assign o_job.mode = r_mode;
    assign o_job.ar   = ar;
    assign o_job.ac   = ac;
    assign o_job.bc   = bc;
endmodule
`default_nettype wire

// File: src/mae_cmdq.sv
// Two-entry job queue between loader and compute sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mae_cmdq (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  mae_pkg::t_job i_job,
    input  wire logic     i_pop,
    output logic          o_valid,
    output mae_pkg::t_job o_job
);
    import mae_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

// File: src/mae_back.sv
// Compute sequencer: matrix stores, shared MAC, saturation, result FIFO.
`timescale 1ns / 1ps
`default_nettype none
module mae_back #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  mae_pkg::t_wr  i_wr,
    input  wire logic     i_job_valid,
    input  mae_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_job_done,
    input  wire logic     pop,
    output logic          empty,
    output mae_pkg::t_res o_res
);
    import mae_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int PW    = 2 * DATA_W;
    localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
    localparam int FQ    = 4;

    logic [DATA_W-1:0] r_a_mem [DEPTH];
    logic [DATA_W-1:0] r_b_mem [DEPTH];
    logic [DATA_W-1:0] r_a_q, r_b_q;

    t_state r_state, n_state;
    t_job   r_job;
    logic [IW-1:0]          r_row, r_col, r_k;
    logic signed [PW-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic [DIM_W-1:0]  orows, ocols;
    logic [CNT_W-1:0]  a_idx, b_idx;
    logic              k_end, c_end, r_end, fifo_full, fpush, fpop;
    logic signed [ACC_W-1:0] sh;
    logic [ACC_W-DATA_W:0]   hi;
    logic [DATA_W:0]         s33;
    t_res              elem;

    t_res       r_fifo [FQ];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_fcnt;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_a) r_a_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        if (i_wr.we_b) r_b_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        r_a_q <= r_a_mem[a_idx[AW-1:0]];
        r_b_q <= r_b_mem[b_idx[AW-1:0]];
    end

    assign orows = (r_job.mode == MODE_TRN) ? r_job.ac : r_job.ar;
    assign ocols = (r_job.mode == MODE_MUL) ? r_job.bc :
                   (r_job.mode == MODE_TRN) ? r_job.ar : r_job.ac;

    always_comb begin
        case (r_job.mode)
            MODE_MUL: begin
                a_idx = CNT_W'(r_row) * CNT_W'(r_job.ac) + CNT_W'(r_k);
                b_idx = CNT_W'(r_k) * CNT_W'(r_job.bc) + CNT_W'(r_col);
            end
            MODE_TRN: begin
                a_idx = CNT_W'(r_col) * CNT_W'(r_job.ac) + CNT_W'(r_row);
                b_idx = a_idx;
            end
            default: begin
                a_idx = CNT_W'(r_row) * CNT_W'(r_job.ac) + CNT_W'(r_col);
                b_idx = a_idx;
            end
        endcase
    end

    assign k_end = ({1'b0, r_k} == (IW + 1)'(r_job.ac - DIM_W'(1)));
    assign c_end = ({1'b0, r_col} == (IW + 1)'(ocols - DIM_W'(1)));
    assign r_end = ({1'b0, r_row} == (IW + 1)'(orows - DIM_W'(1)));

    // result element
    always_comb begin
        sh  = r_acc >>> FRAC_BITS;
        hi  = sh[ACC_W-1:DATA_W-1];
        s33 = (r_job.mode == MODE_SUB) ?
              {r_a_q[DATA_W-1], r_a_q} - {r_b_q[DATA_W-1], r_b_q} :
              {r_a_q[DATA_W-1], r_a_q} + {r_b_q[DATA_W-1], r_b_q};
        elem.row  = IDX_OUT_W'(r_row);
        elem.col  = IDX_OUT_W'(r_col);
        elem.last = c_end && r_end;
        case (r_job.mode)
            MODE_MUL: begin
                elem.sat = !((&hi) || !(|hi));
                if (!elem.sat) begin
                    elem.value = sh[DATA_W-1:0];
                end else begin
                    elem.value = r_acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                : {1'b0, {(DATA_W-1){1'b1}}};
                end
            end
            MODE_TRN: begin
                elem.sat   = 1'b0;
                elem.value = r_a_q;
            end
            default: begin
                elem.sat = (s33[DATA_W] != s33[DATA_W-1]);
                if (!elem.sat) begin
                    elem.value = s33[DATA_W-1:0];
                end else begin
                    elem.value = s33[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}};
                end
            end
        endcase
    end

    assign fifo_full = (r_fcnt == 3'(FQ));

    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        o_job_done = 1'b0;
        fpush      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_RD:  n_state = S_MUL;
            S_MUL: n_state = (r_job.mode == MODE_MUL) ? S_ACC : S_OUT;
            S_ACC: n_state = k_end ? S_OUT : S_RD;
            S_OUT: begin
                if (!fifo_full) begin
                    fpush   = 1'b1;
                    n_state = (c_end && r_end) ? S_DONE : S_RD;
                end
            end
            S_DONE: begin
                o_job_done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
            r_acc <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed(r_a_q) * $signed(r_b_q);
        end
        if (r_state == S_ACC) begin
            r_acc <= r_acc + {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};
            if (!k_end) r_k <= r_k + IW'(1);
        end
        if (fpush) begin
            r_k   <= '0;
            r_acc <= '0;
            if (c_end) begin
                r_col <= '0;
                r_row <= r_row + IW'(1);
            end else begin
                r_col <= r_col + IW'(1);
            end
        end
    end

    // result FIFO
    assign fpop  = pop && (r_fcnt != '0);
    assign empty = (r_fcnt == '0);
    assign o_res = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (fpush) r_fifo[r_wp] <= elem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (fpush) r_wp <= r_wp + 2'd1;
            if (fpop)  r_rp <= r_rp + 2'd1;
            r_fcnt <= r_fcnt + {2'b0, fpush} - {2'b0, fpop};
        end
    end
endmodule
`default_nettype wire

// File: src/mae_checker.sv
// Port-level checks for the matrix arithmetic engine, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module mae_port_checks (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_result_value,
    input wire logic        o_last
);
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("results present after reset");

    a_rst_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !full) else $error("input blocked after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_result_value) && $stable(o_last)))
        else $error("stalled result changed");
endmodule

bind matrix_arith_engine mae_port_checks u_mae_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_result_value (o_result_value),
    .o_last         (o_last)
);
`default_nettype wire

// File: tb/mae_checker.sv
// Checker for the matrix arithmetic engine: predicts results and compares transfers.
`timescale 1ns / 1ps
module mae_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [mae_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic                          i_push,
    input  wire logic                          i_full,
    input  wire logic [mae_pkg::DATA_W-1:0]    i_elem_value,
    input  wire logic                          i_empty,
    input  wire logic                          i_pop,
    input  wire logic [mae_pkg::DATA_W-1:0]    i_result_value,
    input  wire logic [mae_pkg::IDX_OUT_W-1:0] i_result_row,
    input  wire logic [mae_pkg::IDX_OUT_W-1:0] i_result_col,
    input  wire logic                          i_saturated,
    input  wire logic                          i_last,
    output int                                 o_errors,
    output int                                 o_pending
);
    import mae_pkg::*;

    localparam int FRAC = FRAC_DEF;
    localparam int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    t_mode            cur_mode;
    logic [DIM_W-1:0] rows_reg, cols_reg, bcols_reg;
    logic [31:0]      mat_a [DEPTH];
    logic [31:0]      mat_b [DEPTH];
    int               fill_cnt;
    bit               filling_b;
    t_res             expected_q [$];

    function automatic int eff_dim(logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(d);
    endfunction

    // Row r of A times column c of B, exact wide sum, floor shift, clip.
    function automatic logic [32:0] dot_product(int r, int c, int ac, int bc);
        logic signed [127:0] acc;
        logic signed [127:0] sh;
        longint              prod;
        acc = '0;
        for (int k = 0; k < ac; k++) begin
            prod = longint'($signed(mat_a[r*ac+k])) * longint'($signed(mat_b[k*bc+c]));
            acc = acc + {{64{prod[63]}}, prod};
        end
        sh = acc >>> FRAC;
        if (sh > Q_MAX) return {1'b1, 32'h7fffffff};
        if (sh < Q_MIN) return {1'b1, 32'h80000000};
        return {1'b0, sh[31:0]};
    endfunction

    task automatic take_element(logic [31:0] v);
        int ar, ac, bc, need, orows, ocols;
        logic signed [32:0] x, y, s;
        logic [32:0] sv;
        t_res res;
        ar = eff_dim(rows_reg);
        ac = eff_dim(cols_reg);
        bc = eff_dim(bcols_reg);
        // transpose chosen mid-B: the held A is dropped, restart on A
        if (filling_b && cur_mode == MODE_TRN) begin
            filling_b = 0;
            fill_cnt = 0;
        end
        if (!filling_b) begin
            if (fill_cnt < DEPTH) mat_a[fill_cnt] = v;
            fill_cnt = (fill_cnt + 1) & 127;
            if (fill_cnt < ar * ac) return;
            fill_cnt = 0;
            if (cur_mode != MODE_TRN) begin
                filling_b = 1;
                return;
            end
        end else begin
            if (fill_cnt < DEPTH) mat_b[fill_cnt] = v;
            fill_cnt = (fill_cnt + 1) & 127;
            need = (cur_mode == MODE_MUL) ? ac * bc : ar * ac;
            if (fill_cnt < need) return;
            fill_cnt = 0;
            filling_b = 0;
        end
        orows = (cur_mode == MODE_TRN) ? ac : ar;
        ocols = (cur_mode == MODE_MUL) ? bc : (cur_mode == MODE_TRN) ? ar : ac;
        for (int r = 0; r < orows; r++) begin
            for (int c = 0; c < ocols; c++) begin
                case (cur_mode)
                    MODE_MUL: sv = dot_product(r, c, ac, bc);
                    MODE_TRN: sv = {1'b0, mat_a[c*ac+r]};
                    default: begin
                        x = {mat_a[r*ac+c][31], mat_a[r*ac+c]};
                        y = {mat_b[r*ac+c][31], mat_b[r*ac+c]};
                        s = (cur_mode == MODE_ADD) ? x + y : x - y;
                        if (s > 33'sh07fffffff)       sv = {1'b1, 32'h7fffffff};
                        else if (s < -33'sh080000000) sv = {1'b1, 32'h80000000};
                        else                          sv = {1'b0, s[31:0]};
                    end
                endcase
                res.value = sv[31:0];
                res.sat   = sv[32];
                res.row   = IDX_OUT_W'(r);
                res.col   = IDX_OUT_W'(c);
                res.last  = (r == orows - 1) && (c == ocols - 1);
                expected_q.push_back(res);
            end
        end
    endtask

    task automatic check_result();
        t_res want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result value %h row %0d col %0d", $time,
                     i_result_value, i_result_row, i_result_col);
            o_errors++;
            return;
        end
        want = expected_q.pop_front();
        if (want.value !== i_result_value || want.row !== i_result_row ||
            want.col !== i_result_col || want.sat !== i_saturated ||
            want.last !== i_last) begin
            $display("%0t: mismatch expected val %h r %0d c %0d sat %0b last %0b",
                     $time, want.value, want.row, want.col, want.sat, want.last);
            $display("%0t:          actual   val %h r %0d c %0d sat %0b last %0b",
                     $time, i_result_value, i_result_row, i_result_col, i_saturated, i_last);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode  = MODE_MUL;
            rows_reg  = DIM_W'(4);
            cols_reg  = DIM_W'(4);
            bcols_reg = DIM_W'(4);
            fill_cnt  = 0;
            filling_b = 0;
            o_errors  = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:   cur_mode  = t_mode'(i_cfg_data[1:0]);
                    CFG_A_ROWS: rows_reg  = i_cfg_data;
                    CFG_A_COLS: cols_reg  = i_cfg_data;
                    CFG_B_COLS: bcols_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) take_element(i_elem_value);
            if (i_pop && !i_empty) check_result();
        end
        o_pending = expected_q.size();
    end
endmodule

// File: tb/matrix_arith_engine_test.sv
// Testbench top for the matrix arithmetic engine: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module matrix_arith_engine_test;
    import mae_pkg::*;

    localparam int ITEM_TARGET = 370;
    // slowest run is far below this even with every stall
    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = CFG_MODE;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 push = 1'b0;
    logic [DATA_W-1:0]    i_elem_value = '0;
    logic                 pop = 1'b0;
    logic                 full, empty;
    logic [DATA_W-1:0]    o_result_value;
    logic [IDX_OUT_W-1:0] o_result_row, o_result_col;
    logic                 o_saturated, o_last;
    int                   errors, pending;

    int cycles = 0;
    int items_sent = 0;
    int burst_left = 4;
    int stall_pct = 0;   // receiver stall odds in percent

    matrix_arith_engine i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .push, .full, .i_elem_value, .empty, .pop,
        .o_result_value, .o_result_row, .o_result_col, .o_saturated, .o_last
    );

    mae_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push(push), .i_full(full), .i_elem_value,
        .i_empty(empty), .i_pop(pop),
        .i_result_value(o_result_value), .i_result_row(o_result_row),
        .i_result_col(o_result_col), .i_saturated(o_saturated), .i_last(o_last),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("matrix_arith_engine_test: FAIL");
            $finish;
        end
    end

    // Receiver: random pop with a per-phase stall rate; rate 0 never stalls.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // One element transfer. Sender runs in bursts; push stays high across
    // back-to-back transfers. full only moves at posedge, so the negedge
    // sample tells whether the coming edge accepts.
    task automatic send_elem(logic [31:0] v);
        bit stalled;
        push <= 1'b1;
        i_elem_value <= v;
        do begin
            @(negedge i_clk);
            stalled = full;
            @(posedge i_clk);
        end while (stalled);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [DIM_W-1:0] data);
        push <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the sender until every expected transfer has come out, then let
    // the engine settle before the next register write.
    task automatic drain();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_all(t_mode m, logic [3:0] ar, logic [3:0] ac, logic [3:0] bc);
        drain();
        cfg_write(CFG_MODE, DIM_W'(m));
        cfg_write(CFG_A_ROWS, ar);
        cfg_write(CFG_A_COLS, ac);
        cfg_write(CFG_B_COLS, bc);
    endtask

    function automatic int eff(logic [3:0] d);
        return (d == 0) ? 1 : (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
    endfunction

    // Mostly modest Q16.16 values so products stay in range, with some
    // full-range words and the corner values mixed in.
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h3ffff))
                                                  : -32'($urandom_range(0, 32'h3ffff));
        if (sel < 85) return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            default: return 32'h00010000;
        endcase
    endfunction

    task automatic send_rand(int n);
        for (int i = 0; i < n; i++) send_elem(pick_value());
    endtask

    function automatic logic [3:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 4'd0;                        // treated as 1
        if (sel == 1) return 4'($urandom_range(9, 15));   // treated as MAX_DIM
        if (sel < 4) return 4'($urandom_range(5, 8));
        return 4'($urandom_range(1, 4));
    endfunction

    initial begin
        t_mode m;
        logic [3:0] ar, ac, bc, ar2;
        int na, nb, k, rest, variant;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // 1x2 times 2x1 of the largest value: positive clip
        set_all(MODE_MUL, 4'd1, 4'd2, 4'd1);
        send_elem(32'h7fffffff); send_elem(32'h7fffffff);
        send_elem(32'h7fffffff); send_elem(32'h7fffffff);
        // min times min and min times max: both clip, opposite signs
        set_all(MODE_MUL, 4'd1, 4'd1, 4'd1);
        send_elem(32'h80000000); send_elem(32'h80000000);
        send_elem(32'h80000000); send_elem(32'h7fffffff);
        // add clips each way
        set_all(MODE_ADD, 4'd1, 4'd2, 4'd8);
        send_elem(32'h7fffffff); send_elem(32'h80000000);
        send_elem(32'h00000001); send_elem(32'hffffffff);
        // subtract below the floor
        set_all(MODE_SUB, 4'd1, 4'd1, 4'd1);
        send_elem(32'h80000000); send_elem(32'h00000001);
        // zero column count acts as one
        set_all(MODE_TRN, 4'd2, 4'd0, 4'd0);
        send_elem(32'h12345678); send_elem(32'hedcba987);
        // oversize row count acts as MAX_DIM
        set_all(MODE_TRN, 4'd15, 4'd1, 4'd15);
        send_rand(8);
        // transpose picked while B is due: A is dropped, next item starts over
        set_all(MODE_MUL, 4'd1, 4'd1, 4'd1);
        send_elem(32'h00020000);
        drain();
        cfg_write(CFG_MODE, DIM_W'(MODE_TRN));
        send_elem(32'h00030000);

        // ---- random ----
        while (items_sent < ITEM_TARGET) begin
            m  = t_mode'($urandom_range(0, 3));
            ar = pick_dim();
            ac = pick_dim();
            bc = pick_dim();
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            set_all(m, ar, ac, bc);
            na = eff(ar) * eff(ac);
            nb = (m == MODE_MUL) ? eff(ac) * eff(bc) : na;
            variant = $urandom_range(0, 7);
            if (variant == 0 && m != MODE_TRN) begin
                // drop a loaded A by switching to transpose
                send_rand(na);
                drain();
                cfg_write(CFG_MODE, DIM_W'(MODE_TRN));
                m = MODE_TRN;
                send_rand(na);
            end else if (variant == 1 && na > 1) begin
                // row count changed part way through loading A
                k = $urandom_range(1, na - 1);
                send_rand(k);
                drain();
                ar2 = 4'($urandom_range(1, 8));
                cfg_write(CFG_A_ROWS, ar2);
                ar = ar2;
                na = eff(ar) * eff(ac);
                rest = (na > k) ? na - k : 1;
                send_rand(rest);
                nb = (m == MODE_MUL) ? eff(ac) * eff(bc) : na;
                if (m != MODE_TRN) send_rand(nb);
            end
            repeat ($urandom_range(1, 3)) begin
                send_rand(na);
                if (m != MODE_TRN) send_rand(nb);
            end
        end

        drain();
        if (errors == 0) begin
            $display("matrix_arith_engine_test: PASS");
        end else begin
            $display("matrix_arith_engine_test: FAIL");
        end
        $finish;
    end
endmodule
